// ----- design/duplicate_frame_filter_top_defines.svh -----
// ----------------------------------------------------------------------------
// Duplicate frame filter assertion macros
// Shared assertion forms used by the filter top level.
// ----------------------------------------------------------------------------
`ifndef DUPLICATE_FRAME_FILTER_TOP_DEFINES_SVH
`define DUPLICATE_FRAME_FILTER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DFF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DFF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/dff_pkg.sv -----
// ----------------------------------------------------------------------------
// Duplicate frame filter package
// Types, codes and reset values shared by the filter modules.
// ----------------------------------------------------------------------------
package dff_pkg;

  // Default number of remembered frames.
  localparam int TABLE_ENTRIES_DEF = 10;

  // Fixed field widths.
  localparam int BYTE_W  = 8;
  localparam int TIME_W  = 32;
  localparam int AGE_W   = 16;
  localparam int INDEX_W = 6;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  // Register reset values.
  localparam logic [AGE_W-1:0]  AGE_LIMIT_RESET  = 16'd5;
  localparam logic [BYTE_W-1:0] CHECK_SEED_RESET = 8'h34;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_AGE_LIMIT  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHECK_SEED = 1'b1;

  // Lookup outcome.
  typedef enum logic [1:0] {
    VERDICT_NEW      = 2'd0,
    VERDICT_REPEATED = 2'd1,
    VERDICT_FULL     = 2'd2
  } verdict_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } seq_state_t;

  // One remembered frame.
  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [BYTE_W-1:0] check;
    logic [BYTE_W-1:0] source;
  } entry_t;

  // Table port strobes from the sequencer.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_en;
  } tbl_ctl_t;

  // Outcome of comparing one entry with the frame.
  typedef struct packed {
    logic expire;
    logic match;
    logic empty;
  } cmp_res_t;

  // One finished result.
  typedef struct packed {
    verdict_t           verdict;
    logic [BYTE_W-1:0]  check;
    logic [INDEX_W-1:0] index;
  } result_t;

endpackage

// ----- design/dff_table.sv -----
// ----------------------------------------------------------------------------
// Duplicate frame filter table
// Entry memory with one registered read port, one write port and a valid
// flag per entry held in flip-flops.
// ----------------------------------------------------------------------------
module dff_table #(
  parameter int Entries = dff_pkg::TABLE_ENTRIES_DEF,
  parameter int IdxW    = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  dff_pkg::tbl_ctl_t ctl,
  input  logic [IdxW-1:0]   rd_addr,
  input  logic [IdxW-1:0]   wr_addr,
  input  dff_pkg::entry_t   wr_word,
  input  logic [IdxW-1:0]   clr_addr,
  output dff_pkg::entry_t   rd_word,
  output logic              rd_entry_valid,
  output logic              rd_vld,
  output logic [IdxW-1:0]   rd_idx
);
  import dff_pkg::*;

  entry_t             mem [Entries];
  logic [Entries-1:0] valid;

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    if (ctl.rd_en) begin
      rd_word <= mem[rd_addr];
    end
    rd_idx <= rd_addr;
  end

  // Valid flags and read strobe; a write marks the slot as taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
      rd_entry_valid <= 1'b0;
    end else begin
      rd_vld <= ctl.rd_en;
      if (ctl.rd_en) begin
        rd_entry_valid <= valid[rd_addr];
      end
      if (ctl.clr_en) begin
        valid[clr_addr] <= 1'b0;
      end
      if (ctl.wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
    end
  end

endmodule

// ----- design/dff_cmp.sv -----
// ----------------------------------------------------------------------------
// Duplicate frame filter entry compare
// Shared unit that ages one entry and compares it with the ending frame.
// ----------------------------------------------------------------------------
module dff_cmp (
  input  dff_pkg::entry_t                   ent,
  input  logic                              ent_valid,
  input  logic [dff_pkg::TIME_W-1:0]        now_time,
  input  logic [dff_pkg::BYTE_W-1:0]        source,
  input  logic [dff_pkg::BYTE_W-1:0]        check,
  input  logic [dff_pkg::AGE_W-1:0]         age_limit,
  output dff_pkg::cmp_res_t                 res
);
  import dff_pkg::*;

  logic [TIME_W-1:0] age;
  logic              too_old;

  // Age wraps modulo 2^32, so an entry stamped in the future looks very old.
  always_comb begin
    age     = now_time - ent.stamp;
    too_old = age > {{(TIME_W-AGE_W){1'b0}}, age_limit};
    res.expire = ent_valid && too_old;
    res.empty  = !ent_valid || too_old;
    res.match  = ent_valid && !too_old && (ent.source == source) &&
                 (ent.check == check);
  end

endmodule

// ----- design/dff_seq.sv -----
// ----------------------------------------------------------------------------
// Duplicate frame filter sequencer
// Folds payload bytes into the running check and, at the end of a frame,
// sweeps the table one entry a cycle through the compare unit.
// ----------------------------------------------------------------------------
module dff_seq #(
  parameter int Entries = dff_pkg::TABLE_ENTRIES_DEF,
  parameter int IdxW    = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  // Input stream
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [dff_pkg::BYTE_W-1:0]   payload_byte,
  input  logic                         byte_present,
  input  logic                         last_byte,
  input  logic [dff_pkg::BYTE_W-1:0]   source_node,
  input  logic [dff_pkg::TIME_W-1:0]   now_time,
  // Configuration
  input  logic                         seed_load,
  input  logic [dff_pkg::BYTE_W-1:0]   check_seed,
  input  logic [dff_pkg::AGE_W-1:0]    age_limit,
  // Table
  output dff_pkg::tbl_ctl_t            tbl_ctl,
  output logic [IdxW-1:0]              rd_addr,
  output logic [IdxW-1:0]              wr_addr,
  output dff_pkg::entry_t              wr_word,
  output logic [IdxW-1:0]              clr_addr,
  input  dff_pkg::entry_t              rd_word,
  input  logic                         rd_entry_valid,
  input  logic                         rd_vld,
  input  logic [IdxW-1:0]              rd_idx,
  // Result
  input  logic                         out_free,
  output logic                         res_load,
  output dff_pkg::result_t             res
);
  import dff_pkg::*;

  localparam int CntW = $clog2(Entries + 1);
  localparam logic [CntW-1:0] CntEnd = CntW'(Entries);

  seq_state_t        state, state_next;
  logic [BYTE_W-1:0] running_check;
  logic [BYTE_W-1:0] frame_check;
  logic [BYTE_W-1:0] frame_source;
  logic [TIME_W-1:0] frame_now;
  logic [CntW-1:0]   cnt;
  logic              hit_found, free_found;
  logic [IdxW-1:0]   hit_idx, free_idx;
  logic              accept, frame_close;
  cmp_res_t          cmp;

  assign accept      = in_valid && in_ready;
  assign frame_close = accept && last_byte;

  // Shared compare unit, fed from the table read port.
  dff_cmp u_cmp (
    .ent       (rd_word),
    .ent_valid (rd_entry_valid),
    .now_time  (frame_now),
    .source    (frame_source),
    .check     (frame_check),
    .age_limit (age_limit),
    .res       (cmp)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, table strobes and result.
  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    tbl_ctl.rd_en  = 1'b0;
    tbl_ctl.wr_en  = 1'b0;
    tbl_ctl.clr_en = rd_vld && cmp.expire;
    rd_addr        = cnt[IdxW-1:0];
    clr_addr       = rd_idx;
    wr_addr        = hit_found ? hit_idx : free_idx;
    wr_word.stamp  = frame_now;
    wr_word.check  = frame_check;
    wr_word.source = frame_source;
    res_load       = 1'b0;
    res.check      = frame_check;
    if (hit_found) begin
      res.verdict = VERDICT_REPEATED;
      res.index   = INDEX_W'(hit_idx);
    end else if (free_found) begin
      res.verdict = VERDICT_NEW;
      res.index   = INDEX_W'(free_idx);
    end else begin
      res.verdict = VERDICT_FULL;
      res.index   = '0;
    end
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (frame_close) begin
          state_next = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        tbl_ctl.rd_en = (cnt != CntEnd);
        if (cnt == CntEnd) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          res_load      = 1'b1;
          tbl_ctl.wr_en = hit_found || free_found;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Running check, sweep counter and first hit and free slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_check <= CHECK_SEED_RESET;
      cnt           <= '0;
      hit_found     <= 1'b0;
      free_found    <= 1'b0;
    end else begin
      if (seed_load) begin
        running_check <= check_seed;
      end else if (accept) begin
        if (last_byte) begin
          running_check <= check_seed;
        end else if (byte_present) begin
          running_check <= running_check ^ payload_byte;
        end
      end
      if (frame_close) begin
        cnt        <= '0;
        hit_found  <= 1'b0;
        free_found <= 1'b0;
      end else if (state == ST_SWEEP) begin
        if (cnt != CntEnd) begin
          cnt <= cnt + 1'b1;
        end
        if (rd_vld && !hit_found && cmp.match) begin
          hit_found <= 1'b1;
          hit_idx   <= rd_idx;
        end
        if (rd_vld && !free_found && cmp.empty) begin
          free_found <= 1'b1;
          free_idx   <= rd_idx;
        end
      end
    end
  end

  // Frame fields captured with the last word; a byte on it is folded in.
  always_ff @(posedge clk) begin
    if (frame_close) begin
      frame_check  <= byte_present ? (running_check ^ payload_byte) : running_check;
      frame_source <= source_node;
      frame_now    <= now_time;
    end
  end

endmodule

// ----- design/duplicate_frame_filter_top.sv -----
// ----------------------------------------------------------------------------
// Duplicate frame filter
// Folds frame payload words into an XOR check and, at the end of each frame,
// reports whether the same source and check were seen recently.
// ----------------------------------------------------------------------------
// A payload word without tlast is taken and the block is ready again at
// once. A word with tlast starts a sweep of the frame table through one
// shared age and match compare unit, one entry a cycle from a memory with
// a registered read port, so the block is busy for the sweep and the result
// hand-off after that word, and longer only while the previous result has
// not been taken. The result sits in an output register, so a new frame
// can start while it waits. Configuration writes are taken in any cycle
// but are meant for when the block is idle; writing the seed restarts the
// running check.
module duplicate_frame_filter_top #(
  parameter int TableEntries = dff_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // Input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [47:0]                        s_tdata,  // payload_byte, source_node, now_time
  input  logic                               s_tuser,  // byte_present
  input  logic                               s_tlast,  // last_byte
  // Result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [15:0]                        m_tdata,  // frame_check, entry_index, zero pad
  output logic [1:0]                         m_tuser,  // verdict
  // Configuration
  input  logic                               cfg_we,
  input  logic [dff_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [dff_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dff_pkg::*;

  localparam int IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;

  logic [AGE_W-1:0]  age_limit;
  logic [BYTE_W-1:0] check_seed;
  logic              seed_load;
  tbl_ctl_t          tbl_ctl;
  logic [IdxW-1:0]   rd_addr, wr_addr, clr_addr, rd_idx;
  entry_t            wr_word, rd_word;
  logic              rd_entry_valid, rd_vld;
  logic              out_free, res_load;
  result_t           res, res_q;

  // Configuration registers.
  assign seed_load = cfg_we && (cfg_index == REG_CHECK_SEED);

  always_ff @(posedge clk) begin
    if (rst) begin
      age_limit  <= AGE_LIMIT_RESET;
      check_seed <= CHECK_SEED_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AGE_LIMIT:  age_limit  <= cfg_data;
        REG_CHECK_SEED: check_seed <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  dff_seq #(
    .Entries (TableEntries),
    .IdxW    (IdxW)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .payload_byte   (s_tdata[7:0]),
    .byte_present   (s_tuser),
    .last_byte      (s_tlast),
    .source_node    (s_tdata[15:8]),
    .now_time       (s_tdata[47:16]),
    .seed_load      (seed_load),
    .check_seed     (seed_load ? cfg_data[BYTE_W-1:0] : check_seed),
    .age_limit      (age_limit),
    .tbl_ctl        (tbl_ctl),
    .rd_addr        (rd_addr),
    .wr_addr        (wr_addr),
    .wr_word        (wr_word),
    .clr_addr       (clr_addr),
    .rd_word        (rd_word),
    .rd_entry_valid (rd_entry_valid),
    .rd_vld         (rd_vld),
    .rd_idx         (rd_idx),
    .out_free       (out_free),
    .res_load       (res_load),
    .res            (res)
  );

  dff_table #(
    .Entries (TableEntries),
    .IdxW    (IdxW)
  ) u_table (
    .clk            (clk),
    .rst            (rst),
    .ctl            (tbl_ctl),
    .rd_addr        (rd_addr),
    .wr_addr        (wr_addr),
    .wr_word        (wr_word),
    .clr_addr       (clr_addr),
    .rd_word        (rd_word),
    .rd_entry_valid (rd_entry_valid),
    .rd_vld         (rd_vld),
    .rd_idx         (rd_idx)
  );

  // Output register.
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_q <= res;
    end
  end

  assign m_tdata = {2'b00, res_q.index, res_q.check};
  assign m_tuser = res_q.verdict;

`include "duplicate_frame_filter_top_defines.svh"

  // A full table always reports slot zero.
  `DFF_ASSERT_SAME(a_full_index_zero, m_tvalid && (m_tuser == VERDICT_FULL), m_tdata[13:8] == '0, "full verdict with nonzero slot")
  // A reported slot lies inside the table; one spare bit keeps a full-size table in range.
  `DFF_ASSERT_SAME(a_index_in_range, m_tvalid && (m_tuser != VERDICT_FULL), {1'b0, m_tdata[13:8]} < (INDEX_W + 1)'(TableEntries), "slot outside the table")
  // The end of a frame starts the sweep, which holds off input.
  `DFF_ASSERT_NEXT(a_busy_after_last, s_tvalid && s_tready && s_tlast, !s_tready, "input taken during the table sweep")

endmodule

// ----- tb/tb_duplicate_frame_filter_top.sv -----
// ----------------------------------------------------------------------------
// Duplicate frame filter testbench
// Drives frames of payload words into the filter and predicts each verdict
// from a private copy of the frame table. Every result is checked field by
// field as it is taken. The run covers a directed opening, random frames
// with repeats, under several register settings and handshake pacings, and
// one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

// Verdict predictor and store of the verdicts still to come from the block.
class frame_verdict_board;
  logic [dff_pkg::AGE_W-1:0]  age_limit;
  logic [dff_pkg::BYTE_W-1:0] check_seed;
  logic [dff_pkg::BYTE_W-1:0] running_check;
  bit                         slot_valid  [dff_pkg::TABLE_ENTRIES_DEF];
  logic [dff_pkg::BYTE_W-1:0] slot_source [dff_pkg::TABLE_ENTRIES_DEF];
  logic [dff_pkg::BYTE_W-1:0] slot_check  [dff_pkg::TABLE_ENTRIES_DEF];
  logic [dff_pkg::TIME_W-1:0] slot_stamp  [dff_pkg::TABLE_ENTRIES_DEF];
  dff_pkg::result_t           verdicts_due[$];
  int                         failures;

  function new();
    age_limit     = dff_pkg::AGE_LIMIT_RESET;
    check_seed    = dff_pkg::CHECK_SEED_RESET;
    running_check = dff_pkg::CHECK_SEED_RESET;
    failures      = 0;
    foreach (slot_valid[k]) begin
      slot_valid[k]  = 1'b0;
      slot_source[k] = '0;
      slot_check[k]  = '0;
      slot_stamp[k]  = '0;
    end
  endfunction

  function int pending();
    return verdicts_due.size();
  endfunction

  // A seed write also restarts the check of any frame in progress.
  function void write_reg(logic [dff_pkg::CFG_INDEX_W-1:0] idx,
                          logic [dff_pkg::CFG_DATA_W-1:0] val);
    if (idx == dff_pkg::REG_AGE_LIMIT) begin
      age_limit = val;
    end else if (idx == dff_pkg::REG_CHECK_SEED) begin
      check_seed    = val[dff_pkg::BYTE_W-1:0];
      running_check = check_seed;
    end
  endfunction

  // Fold one accepted word into the check; at the end of a frame, sweep out
  // stale entries, then look the frame up and note the verdict it earns.
  function void note_word(logic [7:0] pb, logic pres, logic lst, logic [7:0] src,
                          logic [31:0] now);
    dff_pkg::result_t exp_r;
    logic [31:0]      age;
    logic [7:0]       chk;
    int               hit;
    int               free_slot;
    if (pres) running_check = running_check ^ pb;
    if (!lst) return;
    chk = running_check;
    foreach (slot_valid[k]) begin
      age = now - slot_stamp[k];
      if (slot_valid[k] && age > {16'd0, age_limit}) slot_valid[k] = 1'b0;
    end
    hit = -1;
    free_slot = -1;
    foreach (slot_valid[k]) begin
      if (hit < 0 && slot_valid[k] && slot_source[k] == src && slot_check[k] == chk)
        hit = k;
      if (free_slot < 0 && !slot_valid[k]) free_slot = k;
    end
    exp_r.check = chk;
    if (hit >= 0) begin
      slot_stamp[hit] = now;
      exp_r.verdict   = dff_pkg::VERDICT_REPEATED;
      exp_r.index     = 6'(hit);
    end else if (free_slot >= 0) begin
      slot_valid[free_slot]  = 1'b1;
      slot_source[free_slot] = src;
      slot_check[free_slot]  = chk;
      slot_stamp[free_slot]  = now;
      exp_r.verdict          = dff_pkg::VERDICT_NEW;
      exp_r.index            = 6'(free_slot);
    end else begin
      exp_r.verdict = dff_pkg::VERDICT_FULL;
      exp_r.index   = '0;
    end
    running_check = check_seed;
    verdicts_due.push_back(exp_r);
  endfunction

  // Compare one taken result with the oldest verdict due.
  function void check_result(logic [1:0] verdict, logic [7:0] chk, logic [5:0] idx,
                             logic [1:0] pad);
    dff_pkg::result_t exp_r;
    if (verdicts_due.size() == 0) begin
      $display("%0t: result with none due, verdict %0d check %0h index %0d",
               $time, verdict, chk, idx);
      failures++;
      return;
    end
    exp_r = verdicts_due.pop_front();
    if (verdict !== exp_r.verdict) begin
      $display("%0t: verdict mismatch, expected %0d, actual %0d", $time, exp_r.verdict,
               verdict);
      failures++;
    end
    if (chk !== exp_r.check) begin
      $display("%0t: frame check mismatch, expected %02h, actual %02h", $time,
               exp_r.check, chk);
      failures++;
    end
    if (idx !== exp_r.index) begin
      $display("%0t: entry index mismatch, expected %0d, actual %0d", $time, exp_r.index,
               idx);
      failures++;
    end
    if (pad !== 2'b00) begin
      $display("%0t: padding mismatch, expected 0, actual %0d", $time, pad);
      failures++;
    end
  endfunction
endclass

module tb_duplicate_frame_filter_top;
  import dff_pkg::*;

  localparam int SWEEP_CYCLES = TABLE_ENTRIES_DEF + 2;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int LONG_HOLD    = 600;
  localparam int MAX_LEN      = 10;
  localparam int HIST_DEPTH   = 12;
  localparam int PHASES       = 8;
  localparam int PHASE_WORDS  = 132;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [47:0]            s_tdata   = '0;  // payload_byte, source_node, now_time
  logic                   s_tuser   = 1'b0; // byte_present
  logic                   s_tlast   = 1'b0; // last_byte
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [15:0]            m_tdata;          // frame_check, entry_index, zero pad
  logic [1:0]             m_tuser;          // verdict
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  frame_verdict_board board;
  int                 cycle_count    = 0;
  int                 send_idle_pct  = 0;
  int                 stall_pct      = 0;
  logic               hold_toggle    = 1'b0;
  logic               hold_seen      = 1'b0;
  int                 hold_left      = 0;
  logic [31:0]        now_t          = 32'd0;

  // Frame under construction and recently sent frames for replay.
  logic [7:0]         frame_buf [MAX_LEN];
  logic [7:0]         hist_data [HIST_DEPTH][MAX_LEN];
  int                 hist_len  [HIST_DEPTH];
  bit                 hist_tail [HIST_DEPTH];
  logic [7:0]         hist_src  [HIST_DEPTH];
  int                 hist_count = 0;
  int                 hist_wr    = 0;

  duplicate_frame_filter_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: random stalls, or a long hold-off when one is ordered.
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      hold_seen <= 1'b0;
      hold_left <= 0;
    end else if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= LONG_HOLD;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watch both streams and the register port at every edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) board.write_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready)
        board.note_word(s_tdata[7:0], s_tuser, s_tlast, s_tdata[15:8], s_tdata[47:16]);
      if (m_tvalid && m_tready)
        board.check_result(m_tuser, m_tdata[7:0], m_tdata[13:8], m_tdata[15:14]);
    end
  end

  // Offer one word and hold it until it is taken.
  task automatic send_word(input logic [7:0] pb, input logic pres, input logic lst,
                           input logic [7:0] src, input logic [31:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {now, src, pb};
    s_tuser  <= pres;
    s_tlast  <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Wait until every verdict is in and the last sweep has surely ended.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (SWEEP_CYCLES + 8) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Send the frame held in frame_buf. With tail set the final byte rides on
  // the last word; otherwise an empty last word closes the frame. Ignored
  // words are sprinkled in between.
  task automatic send_frame(input int n, input bit tail, input logic [7:0] src);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        send_word(8'($urandom), 1'b0, 1'b0, 8'($urandom), $urandom);
      if (tail && i == n - 1)
        send_word(frame_buf[i], 1'b1, 1'b1, src, now_t);
      else
        send_word(frame_buf[i], 1'b1, 1'b0, 8'($urandom), $urandom);
    end
    if (!tail) send_word(8'($urandom), 1'b0, 1'b1, src, now_t);
  endtask

  // Random frames, many of them replays of recent ones so that hits occur.
  task automatic random_frames(input int n_words);
    int         sent;
    int         n;
    int         slot;
    bit         tail;
    logic [7:0] src;
    sent = 0;
    while (sent < n_words) begin
      // Time mostly creeps forward; now and then it jumps or steps back.
      case ($urandom_range(19))
        0:       now_t = $urandom;
        1:       now_t = now_t - 32'($urandom_range(4, 1));
        default: now_t = now_t + (($urandom_range(3) == 0) ? 32'd0 :
                                  32'($urandom_range(3, 1)));
      endcase
      if (hist_count > 0 && $urandom_range(99) < 40) begin
        slot = $urandom_range(hist_count - 1);
        n    = hist_len[slot];
        tail = hist_tail[slot];
        src  = hist_src[slot];
        for (int k = 0; k < MAX_LEN; k++) frame_buf[k] = hist_data[slot][k];
      end else begin
        n    = ($urandom_range(9) < 7) ? $urandom_range(3) : $urandom_range(MAX_LEN, 4);
        tail = (n > 0) && ($urandom_range(1) == 1);
        src  = ($urandom_range(9) < 7) ? 8'($urandom_range(3)) : 8'($urandom);
        for (int k = 0; k < MAX_LEN; k++) frame_buf[k] = 8'($urandom);
        hist_len[hist_wr]  = n;
        hist_tail[hist_wr] = tail;
        hist_src[hist_wr]  = src;
        for (int k = 0; k < MAX_LEN; k++) hist_data[hist_wr][k] = frame_buf[k];
        hist_wr = (hist_wr + 1) % HIST_DEPTH;
        if (hist_count < HIST_DEPTH) hist_count++;
      end
      send_frame(n, tail, src);
      sent += n + (tail ? 0 : 1);
    end
  endtask

  // Opening cases: empty frames, hits within the age limit, expiry, a full
  // table, time running backwards, and a seed write in mid frame.
  task automatic directed_frames();
    // Empty frame, an ignored word, then the same frame again inside the limit.
    send_word(8'h00, 1'b0, 1'b1, 8'h00, 32'd100);
    send_word(8'hFF, 1'b0, 1'b0, 8'hFF, 32'hFFFF_FFFF);
    send_word(8'h00, 1'b0, 1'b1, 8'h00, 32'd105);
    // Byte on the last word; repeated once both entries are past the limit.
    for (int r = 0; r < 2; r++) begin
      send_word(8'hFF, 1'b1, 1'b0, 8'h00, 32'd0);
      send_word(8'h00, 1'b1, 1'b0, 8'hFF, 32'hFFFF_FFFF);
      send_word(8'h5A, 1'b1, 1'b1, 8'hFF, (r == 0) ? 32'd106 : 32'd112);
    end
    // Fill the table under the longest limit, then hit the first new entry.
    write_cfg(REG_AGE_LIMIT, 16'hFFFF);
    write_cfg(REG_CHECK_SEED, 16'h0000);
    for (int i = 0; i < 10; i++)
      send_word(8'(i + 1), 1'b1, 1'b1, 8'(8'h80 | i), 32'd200);
    send_word(8'h01, 1'b1, 1'b1, 8'h80, 32'd200);
    // Time behind every stamp: the age wraps and the whole table expires.
    send_word(8'h77, 1'b1, 1'b1, 8'h01, 32'd50);
    // A seed write restarts the frame already begun.
    send_word(8'hAA, 1'b1, 1'b0, 8'h00, 32'd0);
    write_cfg(REG_CHECK_SEED, 16'h00C3);
    send_word(8'h00, 1'b0, 1'b1, 8'h02, 32'd50);
    now_t = 32'd60;
  endtask

  initial begin
    logic [15:0] age_val;
    logic [15:0] seed_val;
    board = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    directed_frames();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       age_val = 16'd0;
        1:       age_val = 16'hFFFF;
        2:       age_val = 16'($urandom_range(6, 1));
        3:       age_val = 16'($urandom);
        4:       age_val = 16'd3;
        5:       age_val = 16'd0;
        6:       age_val = 16'hFFFF;
        default: age_val = 16'($urandom_range(20));
      endcase
      case (phase)
        0:       seed_val = 16'h0000;
        1:       seed_val = 16'h00FF;
        default: seed_val = 16'($urandom_range(255));
      endcase
      write_cfg(REG_AGE_LIMIT, age_val);
      write_cfg(REG_CHECK_SEED, seed_val);

      // Pacing: none, sender idle, receiver stalling, both.
      case (phase % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 88; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 88; end
        default: begin send_idle_pct = 23; stall_pct = 23; end
      endcase
      // One phase starts with a long output hold-off against a busy sender.
      if (phase == 4) hold_toggle <= ~hold_toggle;
      random_frames(PHASE_WORDS);

      // Sometimes leave a frame open so the next seed write restarts it.
      if ($urandom_range(1) == 1)
        send_word(8'($urandom), 1'b1, 1'b0, 8'($urandom), $urandom);
    end

    settle();
    if (board.failures == 0 && board.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
